FILE: rtl/fdt_pkg.sv
// Shared types and constants for the file directory table unit.
`default_nettype none

package fdt_pkg;

	// Slot fields on the ports are six bits wide, enough for 64 slots
	localparam int SLOT_W = 6;
	localparam int WORD_W = 32;
	localparam int COUNT_W = 6;

	// Request codes
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_CREATE = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_LOAD   = 2'd3
	} req_t;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_EXISTS    = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_INVALID   = 3'd4
	} status_t;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [WORD_W-1:0] ident;
		logic [WORD_W-1:0] size;
		logic [WORD_W-1:0] start;
	} entry_t;

	// Access request from the sequencer to the table memory
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/fdt_table.sv
// Entry memory with per-slot valid bits; an unwritten slot reads as an empty entry.
`default_nettype none

module fdt_table #(
	parameter int TABLE_ENTRIES = 40,
	parameter int AW = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fdt_pkg::mem_req_t req,
	output fdt_pkg::entry_t      rdata
);
	import fdt_pkg::*;

	entry_t                  mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t                  rdata_q;
	logic                    rvalid_q;

	// Storage array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	// Valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.rd_addr[AW-1:0]];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: rtl/fdt_ctrl.sv
// Request sequencer: scans the table one slot a cycle, then updates and answers.
`default_nettype none

module fdt_ctrl #(
	parameter int TABLE_ENTRIES = 40,
	parameter int AW = 6
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire fdt_pkg::req_t                  req_type,
	input  wire logic [fdt_pkg::WORD_W-1:0]     file_ident,
	input  wire logic [fdt_pkg::SLOT_W-1:0]     load_slot,
	input  wire logic [fdt_pkg::WORD_W-1:0]     load_size,
	input  wire logic [fdt_pkg::WORD_W-1:0]     load_start,
	output fdt_pkg::mem_req_t                   mreq,
	input  wire fdt_pkg::entry_t                rdata,
	output logic                                done,
	output fdt_pkg::status_t                    status,
	output logic [fdt_pkg::WORD_W-1:0]          entry_size,
	output logic [fdt_pkg::WORD_W-1:0]          entry_start,
	output logic [fdt_pkg::SLOT_W-1:0]          slot_index,
	output logic [fdt_pkg::COUNT_W-1:0]         files_in_use
);
	import fdt_pkg::*;

	localparam int COUNT_CAP = (TABLE_ENTRIES < 63) ? TABLE_ENTRIES : 63;
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 done_q;
	logic [COUNT_W-1:0]   count_q;
	logic [AW-1:0]        ptr_q;
	logic                 match_q;
	logic                 hole_q;

	req_t                 req_q;
	logic [WORD_W-1:0]    id_q;
	logic [SLOT_W-1:0]    lslot_q;
	logic [WORD_W-1:0]    lsize_q;
	logic [WORD_W-1:0]    lstart_q;
	logic [AW-1:0]        midx_q;
	logic [WORD_W-1:0]    msize_q;
	logic [WORD_W-1:0]    mstart_q;
	logic [AW-1:0]        hidx_q;

	status_t              status_q;
	logic [WORD_W-1:0]    esize_q;
	logic [WORD_W-1:0]    estart_q;
	logic [SLOT_W-1:0]    sidx_q;

	logic                 accept;
	logic                 load_ok;
	logic                 id_zero;
	logic                 hit;
	logic                 empty;
	logic                 fin;
	status_t              r_status;
	logic [WORD_W-1:0]    r_size;
	logic [WORD_W-1:0]    r_start;
	logic [SLOT_W-1:0]    r_idx;
	logic [COUNT_W-1:0]   count_nxt;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign load_ok = ({1'b0, lslot_q} < (SLOT_W + 1)'(TABLE_ENTRIES));
	assign id_zero = (id_q == '0);
	assign hit     = (rdata.ident == id_q);
	assign empty   = (rdata.ident == '0);

	// Memory accesses per state
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_CHECK: begin
				if (req_q == REQ_LOAD) begin
					mreq.wr_en         = load_ok;
					mreq.wr_addr       = lslot_q;
					mreq.wr_data.ident = id_q;
					mreq.wr_data.size  = lsize_q;
					mreq.wr_data.start = lstart_q;
				end else if (!id_zero) begin
					mreq.rd_en = 1'b1;
				end
			end
			ST_SCAN: begin
				if (ptr_q != LAST) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = SLOT_W'(ptr_q + AW'(1));
				end
			end
			ST_FINISH: begin
				if (req_q == REQ_CREATE && !match_q && hole_q) begin
					mreq.wr_en         = 1'b1;
					mreq.wr_addr       = SLOT_W'(hidx_q);
					mreq.wr_data.ident = id_q;
				end else if (req_q == REQ_DELETE && match_q) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = SLOT_W'(midx_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Result of the request and the new file count
	always_comb begin
		fin       = 1'b0;
		r_status  = STAT_OK;
		r_size    = '0;
		r_start   = '0;
		r_idx     = '0;
		count_nxt = count_q;
		if (state_q == ST_CHECK) begin
			if (req_q == REQ_LOAD) begin
				fin = 1'b1;
				if (load_ok) begin
					r_size  = lsize_q;
					r_start = lstart_q;
					r_idx   = lslot_q;
				end else begin
					r_status = STAT_NOT_FOUND;
				end
			end else if (id_zero) begin
				fin      = 1'b1;
				r_status = STAT_INVALID;
			end
		end else if (state_q == ST_FINISH) begin
			fin = 1'b1;
			unique case (req_q)
				REQ_LOOKUP: begin
					if (match_q) begin
						r_size  = msize_q;
						r_start = mstart_q;
						r_idx   = SLOT_W'(midx_q);
					end else begin
						r_status = STAT_NOT_FOUND;
					end
				end
				REQ_CREATE: begin
					if (match_q) begin
						r_status = STAT_EXISTS;
						r_idx    = SLOT_W'(midx_q);
					end else if (hole_q) begin
						r_idx = SLOT_W'(hidx_q);
						if (count_q < COUNT_W'(COUNT_CAP)) begin
							count_nxt = count_q + COUNT_W'(1);
						end
					end else begin
						r_status = STAT_FULL;
					end
				end
				REQ_DELETE: begin
					if (match_q) begin
						r_size  = msize_q;
						r_start = mstart_q;
						r_idx   = SLOT_W'(midx_q);
						if (count_q != '0) begin
							count_nxt = count_q - COUNT_W'(1);
						end
					end else begin
						r_status = STAT_NOT_FOUND;
					end
				end
				REQ_LOAD: begin
				end
			endcase
		end
	end

	// Sequencer state, scan pointer and search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			ptr_q   <= '0;
			match_q <= 1'b0;
			hole_q  <= 1'b0;
		end else begin
			done_q  <= fin;
			count_q <= count_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					ptr_q   <= '0;
					match_q <= 1'b0;
					hole_q  <= 1'b0;
					state_q <= fin ? ST_IDLE : ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						match_q <= 1'b1;
					end
					if (empty) begin
						hole_q <= 1'b1;
					end
					if (ptr_q == LAST) begin
						state_q <= ST_FINISH;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, first match, first hole and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			id_q     <= file_ident;
			lslot_q  <= load_slot;
			lsize_q  <= load_size;
			lstart_q <= load_start;
		end
		if (state_q == ST_SCAN) begin
			if (hit && !match_q) begin
				midx_q   <= ptr_q;
				msize_q  <= rdata.size;
				mstart_q <= rdata.start;
			end
			if (empty && !hole_q) begin
				hidx_q <= ptr_q;
			end
		end
		if (fin) begin
			status_q <= r_status;
			esize_q  <= r_size;
			estart_q <= r_start;
			sidx_q   <= r_idx;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign entry_size   = esize_q;
	assign entry_start  = estart_q;
	assign slot_index   = sidx_q;
	assign files_in_use = count_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(COUNT_CAP))
		else $error("file count above cap");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.rd_en && mreq.wr_en))
		else $error("read and write in one cycle");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CHECK)
		else $error("accepted request not dispatched");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |=> !done_q || $past(state_q) == ST_CHECK || $past(state_q) == ST_FINISH)
		else $error("strobe from wrong state");

endmodule

`default_nettype wire

FILE: rtl/file_directory_table_unit.sv
// Top level of the file directory table unit.
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          req_type file_ident load_slot load_size load_start
//  result    out        done (one cycle)       status entry_size entry_start slot_index files_in_use
//
// One request at a time. Load and a zero id are answered in the check state, without a scan.
// Lookup, create and delete scan every slot, one memory read a cycle, and
// answer from the finish state after the last slot has been read.
// busy drops in the done cycle, so the next request can be taken then.
// Reset marks every slot empty through valid bits; no clearing pass.
// The result receiver cannot stall; each result beat is shown for one cycle.
`default_nettype none

module file_directory_table_unit #(
	parameter int TABLE_ENTRIES = 40
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire fdt_pkg::req_t              req_type,
	input  wire logic [fdt_pkg::WORD_W-1:0] file_ident,
	input  wire logic [fdt_pkg::SLOT_W-1:0] load_slot,
	input  wire logic [fdt_pkg::WORD_W-1:0] load_size,
	input  wire logic [fdt_pkg::WORD_W-1:0] load_start,
	output logic                            done,
	output fdt_pkg::status_t                status,
	output logic [fdt_pkg::WORD_W-1:0]      entry_size,
	output logic [fdt_pkg::WORD_W-1:0]      entry_start,
	output logic [fdt_pkg::SLOT_W-1:0]      slot_index,
	output logic [fdt_pkg::COUNT_W-1:0]     files_in_use
);
	import fdt_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	mem_req_t mreq;
	entry_t   rdata;

	// Sequencer
	fdt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.file_ident(file_ident),
		.load_slot(load_slot),
		.load_size(load_size),
		.load_start(load_start),
		.mreq(mreq),
		.rdata(rdata),
		.done(done),
		.status(status),
		.entry_size(entry_size),
		.entry_start(entry_start),
		.slot_index(slot_index),
		.files_in_use(files_in_use)
	);

	// Entry memory
	fdt_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rdata(rdata)
	);

endmodule

`default_nettype wire

FILE: bench/file_directory_table_unit_test.sv
// Self-checking testbench for the file directory table unit: directed and random requests.
`timescale 1ns / 1ps

module file_directory_table_unit_test;
	import fdt_pkg::*;

	localparam int SLOTS     = 40;
	localparam int COUNT_CAP = (SLOTS < 63) ? SLOTS : 63;
	localparam int N_ITEMS   = 1050;
	localparam int POOL_N    = 56;

	// One request beat plus its pacing controls
	typedef struct {
		req_t              op;
		logic [WORD_W-1:0] ident;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] size;
		logic [WORD_W-1:0] blk;
		bit                drain;
		int                gap;
	} dir_request_t;

	// One result beat
	typedef struct {
		status_t            status;
		logic [WORD_W-1:0]  size;
		logic [WORD_W-1:0]  blk;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} dir_answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	req_t                req_type = REQ_LOOKUP;
	logic [WORD_W-1:0]   file_ident = '0;
	logic [SLOT_W-1:0]   load_slot = '0;
	logic [WORD_W-1:0]   load_size = '0;
	logic [WORD_W-1:0]   load_start = '0;
	logic                busy;
	logic                done;
	status_t             status;
	logic [WORD_W-1:0]   entry_size;
	logic [WORD_W-1:0]   entry_start;
	logic [SLOT_W-1:0]   slot_index;
	logic [COUNT_W-1:0]  files_in_use;

	dir_request_t        pending_requests[$];
	dir_answer_t         predicted_answers[$];
	logic                req_taken = 1'b0;
	int                  mismatch_count = 0;

	// Shadow copy of the directory
	logic [WORD_W-1:0]   dir_ident[SLOTS];
	logic [WORD_W-1:0]   dir_size[SLOTS];
	logic [WORD_W-1:0]   dir_blk[SLOTS];
	int                  dir_count = 0;
	logic [WORD_W-1:0]   id_pool[POOL_N];

	file_directory_table_unit #(
		.TABLE_ENTRIES(SLOTS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.file_ident  (file_ident),
		.load_slot   (load_slot),
		.load_size   (load_size),
		.load_start  (load_start),
		.done        (done),
		.status      (status),
		.entry_size  (entry_size),
		.entry_start (entry_start),
		.slot_index  (slot_index),
		.files_in_use(files_in_use)
	);

	// Clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lowest slot holding ident, SLOTS when absent
	function automatic int find_ident(logic [WORD_W-1:0] ident);
		for (int i = 0; i < SLOTS; i++)
			if (dir_ident[i] == ident)
				return i;
		return SLOTS;
	endfunction

	// Apply one request to the shadow directory and return its answer
	function automatic dir_answer_t apply_request(dir_request_t rq);
		dir_answer_t a;
		int          hit;
		int          hole;
		a.status = STAT_OK;
		a.size   = '0;
		a.blk    = '0;
		a.slot   = '0;
		if (rq.op == REQ_LOAD) begin
			if (rq.slot < SLOTS) begin
				dir_ident[rq.slot] = rq.ident;
				dir_size[rq.slot]  = rq.size;
				dir_blk[rq.slot]   = rq.blk;
				a.size = rq.size;
				a.blk  = rq.blk;
				a.slot = rq.slot;
			end else begin
				a.status = STAT_NOT_FOUND;
			end
		end else if (rq.ident == '0) begin
			a.status = STAT_INVALID;
		end else begin
			hit = find_ident(rq.ident);
			case (rq.op)
				REQ_LOOKUP: begin
					if (hit < SLOTS) begin
						a.size = dir_size[hit];
						a.blk  = dir_blk[hit];
						a.slot = SLOT_W'(hit);
					end else begin
						a.status = STAT_NOT_FOUND;
					end
				end
				REQ_CREATE: begin
					hole = find_ident('0);
					if (hit < SLOTS) begin
						a.status = STAT_EXISTS;
						a.slot   = SLOT_W'(hit);
					end else if (hole < SLOTS) begin
						dir_ident[hole] = rq.ident;
						dir_size[hole]  = '0;
						dir_blk[hole]   = '0;
						a.slot = SLOT_W'(hole);
						if (dir_count < COUNT_CAP)
							dir_count++;
					end else begin
						a.status = STAT_FULL;
					end
				end
				default: begin
					if (hit < SLOTS) begin
						a.size = dir_size[hit];
						a.blk  = dir_blk[hit];
						a.slot = SLOT_W'(hit);
						dir_ident[hit] = '0;
						dir_size[hit]  = '0;
						dir_blk[hit]   = '0;
						if (dir_count > 0)
							dir_count--;
					end else begin
						a.status = STAT_NOT_FOUND;
					end
				end
			endcase
		end
		a.count = COUNT_W'(dir_count);
		return a;
	endfunction

	function automatic void add_request(req_t op, logic [WORD_W-1:0] ident,
			logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] size, logic [WORD_W-1:0] blk);
		dir_request_t rq;
		rq.op    = op;
		rq.ident = ident;
		rq.slot  = slot;
		rq.size  = size;
		rq.blk   = blk;
		rq.drain = 1'b0;
		rq.gap   = 0;
		pending_requests.push_back(rq);
	endfunction

	// Mostly known ids so that searches hit; some strangers and some zeros
	function automatic logic [WORD_W-1:0] pick_ident();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return id_pool[$urandom_range(POOL_N - 1)];
		else if (roll < 95)
			return $urandom;
		return '0;
	endfunction

	// Driver: re-rolls the idle draw every cycle until the front beat is taken
	always @(negedge clk) begin : driver
		dir_request_t nxt;
		logic         go;
		go = 1'b0;
		if (arst_n) begin
			if (req_taken)
				void'(pending_requests.pop_front());
			if (pending_requests.size() != 0) begin
				nxt = pending_requests[0];
				go  = !(nxt.drain && predicted_answers.size() != 0) &&
				      ($urandom_range(99) >= nxt.gap);
				req_type   <= nxt.op;
				file_ident <= nxt.ident;
				load_slot  <= nxt.slot;
				load_size  <= nxt.size;
				load_start <= nxt.blk;
			end
		end
		start <= go;
	end

	// Monitor: check result beats, then predict for the accepted request
	always @(posedge clk) begin : monitor
		dir_request_t taken;
		dir_answer_t  want;
		req_taken <= arst_n && start && !busy;
		if (arst_n && done) begin
			if (predicted_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result beat with nothing expected: status %0d slot %0d",
						$realtime, status, slot_index);
			end else begin
				want = predicted_answers.pop_front();
				if (status !== want.status || entry_size !== want.size ||
				    entry_start !== want.blk || slot_index !== want.slot ||
				    files_in_use !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: mismatch expected st %0d size %h start %h slot %0d cnt %0d",
							$realtime, want.status, want.size, want.blk, want.slot, want.count);
						$display("%0t:            actual st %0d size %h start %h slot %0d cnt %0d",
							$realtime, status, entry_size, entry_start, slot_index, files_in_use);
					end
				end
			end
		end
		if (arst_n && start && !busy) begin
			taken.op    = req_type;
			taken.ident = file_ident;
			taken.slot  = load_slot;
			taken.size  = load_size;
			taken.blk   = load_start;
			predicted_answers.push_back(apply_request(taken));
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int n_directed;
		int n;
		int kind;
		int s;
		int total;
		for (int i = 0; i < SLOTS; i++) begin
			dir_ident[i] = '0;
			dir_size[i]  = '0;
			dir_blk[i]   = '0;
		end
		id_pool[0] = 32'h0000_0001;
		id_pool[1] = 32'hFFFF_FFFF;
		id_pool[2] = 32'h8000_0000;
		for (int i = 3; i < POOL_N; i++)
			id_pool[i] = $urandom_range(32'hFFFF_FFFF, 1);

		// Directed: empty table, zero ids, underflow, duplicates, bad load slots
		add_request(REQ_LOOKUP, 32'h0000_0001, 6'd0, '0, '0);
		add_request(REQ_LOOKUP, '0, 6'd0, '0, '0);
		add_request(REQ_CREATE, '0, 6'd0, '0, '0);
		add_request(REQ_DELETE, '0, 6'd0, '0, '0);
		add_request(REQ_DELETE, 32'hFFFF_FFFF, 6'd0, '0, '0);
		add_request(REQ_LOAD, 32'hDEAD_BEEF, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(REQ_DELETE, 32'hDEAD_BEEF, 6'd0, '0, '0);
		add_request(REQ_CREATE, 32'h0000_0001, 6'd0, '0, '0);
		add_request(REQ_CREATE, 32'hFFFF_FFFF, 6'd0, '0, '0);
		add_request(REQ_CREATE, 32'h0000_0001, 6'd0, '0, '0);
		add_request(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, '0);
		add_request(REQ_LOAD, 32'h8000_0000, 6'd39, 32'h0000_1234, 32'h0000_5678);
		add_request(REQ_LOAD, 32'h0000_0005, 6'd40, 32'h1111_1111, 32'h2222_2222);
		add_request(REQ_LOAD, 32'h0000_0005, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(REQ_LOAD, 32'h55AA_55AA, 6'd7, 32'h0000_0007, 32'h0000_0070);
		add_request(REQ_LOAD, 32'h55AA_55AA, 6'd3, 32'h0000_0003, 32'h0000_0030);
		add_request(REQ_LOOKUP, 32'h55AA_55AA, 6'd0, '0, '0);
		add_request(REQ_DELETE, 32'h55AA_55AA, 6'd0, '0, '0);
		add_request(REQ_LOOKUP, 32'h55AA_55AA, 6'd0, '0, '0);
		add_request(REQ_LOAD, '0, 6'd1, '0, '0);
		add_request(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, '0);
		add_request(REQ_LOAD, 32'h2AAA_AAAA, 6'd32, 32'h5555_5555, 32'hAAAA_AAAA);
		add_request(REQ_LOOKUP, 32'h2AAA_AAAA, 6'd0, '0, '0);
		add_request(REQ_CREATE, 32'h7FFF_FFFF, 6'd0, '0, '0);
		n_directed = pending_requests.size();

		// Fill to full, then punch holes and refill so the count saturates
		repeat (45)
			add_request(REQ_CREATE, $urandom_range(32'hFFFF_FFFF, 1), SLOT_W'($urandom),
				$urandom, $urandom);
		repeat (8) begin
			add_request(REQ_LOAD, '0, SLOT_W'($urandom_range(SLOTS - 1)), $urandom, $urandom);
			add_request(REQ_CREATE, $urandom_range(32'hFFFF_FFFF, 1), SLOT_W'($urandom),
				$urandom, $urandom);
		end

		// Random episodes, mostly over a shared id pool
		while (pending_requests.size() < N_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				n = $urandom_range(45, 8);
				repeat (n)
					add_request(REQ_CREATE, id_pool[$urandom_range(POOL_N - 1)],
						SLOT_W'($urandom), $urandom, $urandom);
			end else if (kind < 50) begin
				repeat (20)
					add_request(req_t'($urandom_range(2)), pick_ident(),
						SLOT_W'($urandom), $urandom, $urandom);
			end else if (kind < 65) begin
				n = $urandom_range(40, 10);
				repeat (n)
					add_request(REQ_DELETE, pick_ident(), SLOT_W'($urandom),
						$urandom, $urandom);
			end else if (kind < 85) begin
				n = $urandom_range(12, 3);
				repeat (n) begin
					s = ($urandom_range(9) == 0) ? $urandom_range(63, SLOTS)
					                             : $urandom_range(SLOTS - 1);
					add_request(REQ_LOAD, ($urandom_range(4) == 0) ? '0 : pick_ident(),
						SLOT_W'(s), $urandom, $urandom);
				end
			end else begin
				repeat (10)
					add_request(req_t'($urandom_range(3)),
						($urandom_range(9) == 0) ? '0 : $urandom,
						SLOT_W'($urandom), $urandom, $urandom);
			end
		end

		// Idle phases: 38 percent, 85 percent, none; drain at phase edges and now and then
		total = pending_requests.size();
		for (int i = 0; i < total; i++) begin
			pending_requests[i].gap = (i < total / 3) ? 38 : ((i < 2 * total / 3) ? 85 : 0);
			pending_requests[i].drain = (i == n_directed) || (i == total / 3) ||
			                            (i == 2 * total / 3) || ($urandom_range(99) == 0);
		end

		// Hold reset, then release it away from the active edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to go out and every answer to come back
		while (pending_requests.size() != 0 || start || predicted_answers.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);

		if (predicted_answers.size() != 0)
			$display("%0d expected results never arrived", predicted_answers.size());
		if (mismatch_count == 0 && predicted_answers.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/fdt_pkg.sv
rtl/fdt_table.sv
rtl/fdt_ctrl.sv
rtl/file_directory_table_unit.sv
bench/file_directory_table_unit_test.sv
